### sv/byte_ring_buffer_with_marker_seek_top_defines.svh
// assertion macros for the byte ring buffer top level
// expects clk and arst_n in the scope where the macros are used
`ifndef BYTE_RING_BUFFER_WITH_MARKER_SEEK_TOP_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_MARKER_SEEK_TOP_DEFINES_SVH

// condition implies check in the same cycle
`define BRB_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies check in the next cycle
`define BRB_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/brb_pkg.sv
// shared constants, command codes and ram request type for the byte ring buffer
// no dependencies
package brb_pkg;

	localparam int DEPTH      = 4096;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int CAP_W      = 13;
	localparam int MIN_SIZE   = 1025;
	localparam int WORD_BYTES = 4;
	localparam int CMD_W      = 3;

	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SEEK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

### sv/brb_if.sv
// item channels and configuration channel of the byte ring buffer
// depends on brb_pkg
interface brb_in_if import brb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [7:0]       wr_byte;
	logic [31:0]      pattern;
	logic [11:0]      offset;

	modport source (output valid, output cmd, output wr_byte, output pattern,
		output offset, input ready);
	modport sink (input valid, input cmd, input wr_byte, input pattern,
		input offset, output ready);
endinterface

interface brb_out_if import brb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [7:0]       rd_byte;
	logic             done_res;
	logic [CNT_W-1:0] level;

	modport source (output valid, output rd_byte, output done_res, output level,
		input ready);
	modport sink (input valid, input rd_byte, input done_res, input level,
		output ready);
endinterface

interface brb_cfg_if import brb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

### sv/brb_ram.sv
// byte store: one write port, one read port, registered read data
// depends on brb_pkg
module brb_ram import brb_pkg::*; (
	input  logic       clk,
	input  ram_req_t   req,
	output logic [7:0] rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem_q[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

### sv/byte_ring_buffer_with_marker_seek_top.sv
// top level of the byte ring buffer with marker word seek
// depends on brb_pkg, brb_if, brb_ram and the assertion macro header
//
// usage:
//  in_ch carries one command item (cmd, wr_byte, pattern, offset); out_ch returns
//  exactly one result item (rd_byte, done_res, level) per command, in order.
//  cfg_ch writes the capacity register; it is always ready, and a write also
//  empties the buffer and starts a store wipe.
// result paths, accept to result valid:
//  write, clear, unknown code, read or seek on too little data: result registered at accept
//  read with data: through the read wait state; peek: offset reduction, then ram read
//  seek: words examined one byte at a time through the single byte read port of the store
// throughput: writes stream at one item per cycle while the output is taken; every other
//  command holds the input until its result is in the output register
// reset, clear command and capacity write: pointers and level go to zero at once,
//  then a wipe writes zero to all 4096 bytes, one per cycle, during which no item
//  is accepted (config writes still are)
// a stalled output keeps its result item in the output register; the next item
//  is taken in the cycle that register is emptied
`include "byte_ring_buffer_with_marker_seek_top_defines.svh"

module byte_ring_buffer_with_marker_seek_top import brb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	brb_in_if.sink    in_ch,
	brb_out_if.source out_ch,
	brb_cfg_if.sink   cfg_ch
);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_PK_MOD,
		ST_PK_RD,
		ST_SEEK
	} state_t;

	// effective ring size: clamp, round up to a word, keep within the store
	function automatic logic [CNT_W-1:0] size_from_reg(input logic [CAP_W-1:0] r);
		logic [CAP_W:0] s;
		s = {1'b0, r};
		if (s < (CAP_W+1)'(MIN_SIZE)) s = (CAP_W+1)'(MIN_SIZE);
		if (s > (CAP_W+1)'(DEPTH)) s = (CAP_W+1)'(DEPTH);
		s = (s + (CAP_W+1)'(3)) & ~(CAP_W+1)'(3);
		if (s > (CAP_W+1)'(DEPTH)) s = (CAP_W+1)'(DEPTH) & ~(CAP_W+1)'(3);
		return s[CNT_W-1:0];
	endfunction

	// pos + by with one wrap; by never exceeds the ring size
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] pos,
		input logic [CNT_W-1:0] by, input logic [CNT_W-1:0] eff);
		logic [CNT_W:0] p;
		p = (CNT_W+1)'(pos) + (CNT_W+1)'(by);
		if (p >= (CNT_W+1)'(eff)) p = p - (CNT_W+1)'(eff);
		return p[ADDR_W-1:0];
	endfunction

	state_t            state_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [CNT_W-1:0]  eff_q;
	logic [ADDR_W-1:0] rp_q;
	logic [ADDR_W-1:0] wp_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  off_q;
	logic [ADDR_W-1:0] pk_addr_q;
	logic [31:0]       pat_q;
	logic [ADDR_W-1:0] seek_ra_q;
	logic              seek_pend_s1;
	logic [1:0]        byte_k_q;
	logic [23:0]       word_q;

	logic              out_valid_q;
	logic [7:0]        out_rd_q;
	logic              out_done_q;
	logic [CNT_W-1:0]  out_level_q;

	logic              in_acc;
	logic              cfg_acc;
	logic              is_full;
	logic              wr_ok;
	ram_req_t          ram_req;
	logic [7:0]        ram_rd;
	logic [ADDR_W-1:0] rp_plus1;
	logic [ADDR_W-1:0] rp_plus4;
	logic [ADDR_W-1:0] wp_plus1;
	logic [ADDR_W-1:0] seek_ra_next;
	logic [31:0]       seek_word;

	// handshakes
	assign in_ch.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign cfg_acc      = cfg_ch.valid;

	assign is_full = fill_q >= eff_q;
	assign wr_ok   = in_acc && (in_ch.cmd == CMD_WRITE) && !is_full;

	// pointer steps, each a single add and wrap
	assign rp_plus1     = wrap_add(rp_q, CNT_W'(1), eff_q);
	assign rp_plus4     = wrap_add(rp_q, CNT_W'(WORD_BYTES), eff_q);
	assign wp_plus1     = wrap_add(wp_q, CNT_W'(1), eff_q);
	assign seek_ra_next = wrap_add(seek_ra_q, CNT_W'(1), eff_q);

	// newest byte is the top of the little-endian word
	assign seek_word = {ram_rd, word_q};

	// store port: wipe or byte write; read address follows the state
	always_comb begin
		ram_req.we    = (state_q == ST_CLR) || wr_ok;
		ram_req.waddr = (state_q == ST_CLR) ? clr_cnt_q : wp_q;
		ram_req.wdata = (state_q == ST_CLR) ? 8'd0 : in_ch.wr_byte;
		case (state_q)
			ST_PK_RD: ram_req.raddr = pk_addr_q;
			ST_SEEK:  ram_req.raddr = seek_ra_q;
			default:  ram_req.raddr = rp_q;
		endcase
	end

	brb_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_cnt_q    <= '0;
			eff_q        <= size_from_reg(CAP_W'(DEPTH));
			rp_q         <= '0;
			wp_q         <= '0;
			fill_q       <= '0;
			off_q        <= '0;
			pk_addr_q    <= '0;
			pat_q        <= '0;
			seek_ra_q    <= '0;
			seek_pend_s1 <= 1'b0;
			byte_k_q     <= '0;
			word_q       <= '0;
			out_valid_q  <= 1'b0;
			out_rd_q     <= '0;
			out_done_q   <= 1'b0;
			out_level_q  <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_acc) begin
				// new size invalidates the positions: empty and wipe
				eff_q     <= size_from_reg(cfg_ch.capacity);
				rp_q      <= '0;
				wp_q      <= '0;
				fill_q    <= '0;
				clr_cnt_q <= '0;
				state_q   <= ST_CLR;
			end else begin
				case (state_q)
					ST_CLR: begin
						clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
						if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_acc) begin
							case (in_ch.cmd)
								CMD_WRITE: begin
									out_valid_q <= 1'b1;
									out_rd_q    <= '0;
									out_done_q  <= !is_full;
									if (!is_full) begin
										wp_q        <= wp_plus1;
										fill_q      <= fill_q + CNT_W'(1);
										out_level_q <= fill_q + CNT_W'(1);
									end else begin
										out_level_q <= fill_q;
									end
								end
								CMD_READ: begin
									if (fill_q != '0) begin
										// store read issued at this edge
										rp_q    <= rp_plus1;
										fill_q  <= fill_q - CNT_W'(1);
										state_q <= ST_RD_WAIT;
									end else begin
										out_valid_q <= 1'b1;
										out_rd_q    <= '0;
										out_done_q  <= 1'b0;
										out_level_q <= fill_q;
									end
								end
								CMD_SEEK: begin
									pat_q <= in_ch.pattern;
									if (fill_q >= CNT_W'(WORD_BYTES)) begin
										seek_ra_q    <= rp_q;
										seek_pend_s1 <= 1'b0;
										byte_k_q     <= '0;
										state_q      <= ST_SEEK;
									end else begin
										out_valid_q <= 1'b1;
										out_rd_q    <= '0;
										out_done_q  <= 1'b0;
										out_level_q <= fill_q;
									end
								end
								CMD_PEEK: begin
									off_q   <= CNT_W'(in_ch.offset);
									state_q <= ST_PK_MOD;
								end
								CMD_CLEAR: begin
									out_valid_q <= 1'b1;
									out_rd_q    <= '0;
									out_done_q  <= 1'b1;
									out_level_q <= '0;
									rp_q        <= '0;
									wp_q        <= '0;
									fill_q      <= '0;
									clr_cnt_q   <= '0;
									state_q     <= ST_CLR;
								end
								default: begin
									out_valid_q <= 1'b1;
									out_rd_q    <= '0;
									out_done_q  <= 1'b0;
									out_level_q <= fill_q;
								end
							endcase
						end
					end
					ST_PK_MOD: begin
						// offset modulo ring size, at most three subtracts
						if (off_q >= eff_q) begin
							off_q <= off_q - eff_q;
						end else begin
							pk_addr_q <= wrap_add(rp_q, off_q, eff_q);
							state_q   <= ST_PK_RD;
						end
					end
					ST_PK_RD: begin
						state_q <= ST_RD_WAIT;
					end
					ST_RD_WAIT: begin
						out_valid_q <= 1'b1;
						out_rd_q    <= ram_rd;
						out_done_q  <= 1'b1;
						out_level_q <= fill_q;
						state_q     <= ST_IDLE;
					end
					ST_SEEK: begin
						// reads stream from the read position; every fourth
						// byte closes a word. words are aligned to rp_q because
						// the ring size is a multiple of four
						seek_ra_q    <= seek_ra_next;
						seek_pend_s1 <= 1'b1;
						if (seek_pend_s1) begin
							if (byte_k_q != 2'd3) begin
								word_q[byte_k_q*8 +: 8] <= ram_rd;
								byte_k_q                <= byte_k_q + 2'd1;
							end else begin
								byte_k_q <= '0;
								if (seek_word == pat_q) begin
									// marker stays in place
									out_valid_q <= 1'b1;
									out_rd_q    <= '0;
									out_done_q  <= 1'b1;
									out_level_q <= fill_q;
									state_q     <= ST_IDLE;
								end else begin
									rp_q   <= rp_plus4;
									fill_q <= fill_q - CNT_W'(WORD_BYTES);
									if (fill_q < CNT_W'(2 * WORD_BYTES)) begin
										out_valid_q <= 1'b1;
										out_rd_q    <= '0;
										out_done_q  <= 1'b0;
										out_level_q <= fill_q - CNT_W'(WORD_BYTES);
										state_q     <= ST_IDLE;
									end
								end
							end
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.rd_byte  = out_rd_q;
	assign out_ch.done_res = out_done_q;
	assign out_ch.level    = out_level_q;

	// occupancy and both positions stay inside the ring
	`BRB_CHECK_NOW(a_ring_bounds, 1'b1, (fill_q <= eff_q) && (CNT_W'(rp_q) < eff_q) && (CNT_W'(wp_q) < eff_q), "ring pointer or fill out of range")
	// a seek in progress always has a whole word to look at
	`BRB_CHECK_NOW(a_seek_has_word, state_q == ST_SEEK, fill_q >= CNT_W'(WORD_BYTES), "seek running with less than one word held")
	// store writes only come from the wipe or an accepted byte write
	`BRB_CHECK_NOW(a_write_source, ram_req.we, (state_q == ST_CLR) || (state_q == ST_IDLE), "store written outside wipe or idle")
	// a byte write answers in the next cycle
	`BRB_CHECK_NEXT(a_write_answers, in_acc && (in_ch.cmd == CMD_WRITE) && !cfg_acc, out_valid_q, "write item produced no result")

endmodule

### tb/brb_ring_checker.sv
// result checker for the byte ring buffer: keeps its own copy of the ring and capacity,
// predicts one result item per accepted command and compares it with the output channel
// depends on brb_pkg and the brb_if interfaces
`timescale 1ns / 1ps

module brb_ring_checker import brb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	brb_in_if    in_ch,
	brb_out_if   out_ch,
	brb_cfg_if   cfg_ch,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic [7:0]       rd_byte;
		logic             done_res;
		logic [CNT_W-1:0] level;
	} ring_result_t;

	ring_result_t expected_q[$];
	ring_result_t want;

	logic [7:0] shadow_mem [DEPTH];
	int rd_ptr;
	int wr_ptr;
	int held;
	int ring_bytes;
	int errs = 0;

	assign mismatches = errs;

	// clamp to the legal range, then round up to whole words
	function automatic int size_for(input logic [CAP_W-1:0] v);
		int s;
		s = int'(v);
		if (s < MIN_SIZE) s = MIN_SIZE;
		if (s > DEPTH) s = DEPTH;
		s = (s + WORD_BYTES - 1) & ~(WORD_BYTES - 1);
		if (s > DEPTH) s = DEPTH & ~(WORD_BYTES - 1);
		return s;
	endfunction

	function automatic int ring_next(input int p, input int by);
		int q;
		q = p + by;
		while (q >= ring_bytes) q -= ring_bytes;
		return q;
	endfunction

	// little endian: byte at p lands in bits 7..0
	function automatic logic [31:0] word_from(input int p);
		logic [31:0] w;
		for (int k = 0; k < WORD_BYTES; k++) w[8*k +: 8] = shadow_mem[ring_next(p, k)];
		return w;
	endfunction

	function automatic void empty_ring();
		foreach (shadow_mem[i]) shadow_mem[i] = '0;
		rd_ptr = 0;
		wr_ptr = 0;
		held   = 0;
	endfunction

	function automatic ring_result_t apply_command(input logic [CMD_W-1:0] cmd,
		input logic [7:0] b, input logic [31:0] pat, input logic [11:0] off);
		ring_result_t r;
		r = '0;
		case (cmd)
			CMD_WRITE: begin
				if (held < ring_bytes) begin
					shadow_mem[wr_ptr] = b;
					wr_ptr = ring_next(wr_ptr, 1);
					held++;
					r.done_res = 1'b1;
				end
			end
			CMD_READ: begin
				if (held > 0) begin
					r.rd_byte = shadow_mem[rd_ptr];
					rd_ptr = ring_next(rd_ptr, 1);
					held--;
					r.done_res = 1'b1;
				end
			end
			CMD_SEEK: begin
				// matching word stays in place
				while (held >= WORD_BYTES && !r.done_res) begin
					if (word_from(rd_ptr) == pat) begin
						r.done_res = 1'b1;
					end else begin
						rd_ptr = ring_next(rd_ptr, WORD_BYTES);
						held -= WORD_BYTES;
					end
				end
			end
			CMD_PEEK: begin
				r.rd_byte  = shadow_mem[ring_next(rd_ptr, int'(off) % ring_bytes)];
				r.done_res = 1'b1;
			end
			CMD_CLEAR: begin
				empty_ring();
				r.done_res = 1'b1;
			end
			default: begin
			end
		endcase
		r.level = CNT_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			ring_bytes = size_for(CAP_W'(DEPTH));
			empty_ring();
			outstanding <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result item with no command waiting");
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (out_ch.rd_byte !== want.rd_byte) begin
						$error("rd_byte expected %0h got %0h", want.rd_byte, out_ch.rd_byte);
						errs++;
					end
					if (out_ch.done_res !== want.done_res) begin
						$error("done_res expected %0h got %0h", want.done_res, out_ch.done_res);
						errs++;
					end
					if (out_ch.level !== want.level) begin
						$error("level expected %0d got %0d", want.level, out_ch.level);
						errs++;
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				ring_bytes = size_for(cfg_ch.capacity);
				empty_ring();
			end
			if (in_ch.valid && in_ch.ready) begin
				expected_q.push_back(apply_command(in_ch.cmd, in_ch.wr_byte, in_ch.pattern,
					in_ch.offset));
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

### tb/tb_byte_ring_buffer_with_marker_seek_top.sv
// testbench top for the byte ring buffer with marker seek: drives commands and capacity
// writes, idles both sides at random and reports the verdict from brb_ring_checker
// depends on brb_pkg, brb_if, brb_ring_checker and the block itself
`timescale 1ns / 1ps

module tb_byte_ring_buffer_with_marker_seek_top;
	import brb_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int RUN_LIMIT   = 3_000_000;
	localparam int HOLD_AFTER  = 300;   // result count at which the receiver goes quiet
	localparam int HOLD_CYCLES = 500;
	localparam int TAIL_CYCLES = 20;
	localparam int FILL_BYTES  = 1040;  // a bit more than the smallest ring
	localparam int FILL_ITEMS  = 1100;
	localparam int SWEEP_ITEMS = 10;

	// codes the block must treat as no-ops
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	// capacity settings for the later phases: top of the field, both range ends,
	// and values that need rounding
	localparam logic [CAP_W-1:0] SWEEP_CAPS [5] = '{13'h1FFF, 13'd1025, 13'd4095,
		13'd1026, 13'd4096};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int cycle_count = 0;
	int sent        = 0;
	int rx_count    = 0;
	int tx_left     = 0;
	int rx_left     = 0;
	bit tx_quiet    = 1'b0;
	bit rx_quiet    = 1'b0;
	int fails;
	int outstanding;

	logic [31:0] marks [8];

	brb_in_if  in_ch ();
	brb_out_if out_ch ();
	brb_cfg_if cfg_ch ();

	byte_ring_buffer_with_marker_seek_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	brb_ring_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_ch      (cfg_ch),
		.mismatches  (fails),
		.outstanding (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("byte_ring_buffer_with_marker_seek_top verification failed");
			$finish;
		end
	end

	// idle pattern: stretches of 20..80 items, a quarter of them with no gaps at all,
	// the rest with a randomly drawn idle gap, possibly none, before each item
	function automatic int next_gap(ref int left, ref bit quiet);
		if (left == 0) begin
			quiet = ($urandom_range(0, 3) == 0);
			left  = $urandom_range(20, 80);
		end
		left--;
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// offer one command item and hold it until the block takes it; valid stays
	// high into the next item when no gap is drawn
	task automatic issue(input logic [CMD_W-1:0] c, input logic [7:0] b,
		input logic [31:0] p, input logic [11:0] o);
		int gap;
		gap = next_gap(tx_left, tx_quiet);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.cmd     <= c;
		in_ch.wr_byte <= b;
		in_ch.pattern <= p;
		in_ch.offset  <= o;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	// unused fields always carry random values
	task automatic put_byte(input logic [7:0] b);
		issue(CMD_WRITE, b, $urandom, 12'($urandom));
	endtask

	task automatic take_bytes(input int n);
		repeat (n) issue(CMD_READ, 8'($urandom), $urandom, 12'($urandom));
	endtask

	task automatic seek_for(input logic [31:0] p);
		issue(CMD_SEEK, 8'($urandom), p, 12'($urandom));
	endtask

	task automatic peek_at(input logic [11:0] o);
		issue(CMD_PEEK, 8'($urandom), $urandom, o);
	endtask

	// a frame is a marker word followed by whole payload words, so the markers
	// stay word aligned to the read position as long as reads come in words
	task automatic put_frame(input int idx, input int words);
		for (int k = 0; k < 4; k++) put_byte(marks[idx][8*k +: 8]);
		repeat (4 * words) put_byte(8'($urandom));
	endtask

	// one step of the mixed traffic: mostly framed writes, word reads and marker
	// seeks; single byte reads break the alignment so seeks also run dry
	task automatic mixed_action();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			put_frame($urandom_range(0, 7), $urandom_range(0, 6));
		end else if (r < 52) begin
			take_bytes(4 * $urandom_range(1, 4));
		end else if (r < 62) begin
			seek_for(marks[$urandom_range(0, 7)]);
		end else if (r < 72) begin
			// near the read position, at the field ends, or anywhere
			case ($urandom_range(0, 3))
				0: n = $urandom_range(0, 64);
				1: n = $urandom_range(0, 1) ? 4095 : 0;
				default: n = $urandom_range(0, 4095);
			endcase
			peek_at(n[11:0]);
		end else if (r < 78) begin
			take_bytes(1);
		end else if (r < 84) begin
			put_byte(8'($urandom));
		end else if (r < 88) begin
			seek_for($urandom);
		end else if (r < 91) begin
			issue(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), 8'($urandom),
				$urandom, 12'($urandom));
		end else if (r < 93) begin
			// a clear costs a full store wipe, so keep it rare
			issue(CMD_CLEAR, 8'($urandom), $urandom, 12'($urandom));
		end else begin
			// long drain to move the read position across the ring end
			take_bytes($urandom_range(16, 160));
		end
	endtask

	// drop valid and wait until every result item has come back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// capacity writes happen only with nothing in flight; the wipe that follows
	// simply stalls the next command
	task automatic set_capacity(input logic [CAP_W-1:0] v);
		wait_idle();
		cfg_ch.valid    <= 1'b1;
		cfg_ch.capacity <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// receiver: random ready gaps, plus one long hold-off while the sender keeps
	// streaming so that the output register fills and the input stalls
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = next_gap(rx_left, rx_quiet);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			rx_count++;
			if (rx_count == HOLD_AFTER) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// main stimulus
	initial begin
		int filled;
		int idx;
		int phase_end;
		in_ch.valid     <= 1'b0;
		in_ch.cmd       <= CMD_WRITE;
		in_ch.wr_byte   <= '0;
		in_ch.pattern   <= '0;
		in_ch.offset    <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.capacity <= '0;
		foreach (marks[i]) marks[i] = $urandom;

		// single reset at the start; the block wipes its store afterwards and
		// holds off the first command until that is done
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset capacity
		issue(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 12'hFFF);   // read when empty
		seek_for(32'h0000_0000);                          // seek with nothing held
		peek_at(12'h000);
		peek_at(12'hFFF);                                 // far past the held data
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h80);
		put_byte(8'h7F);
		put_byte(8'hEF);
		put_byte(8'hBE);
		put_byte(8'hAD);
		put_byte(8'hDE);
		seek_for(32'hDEAD_BEEF);                          // skips one word, then hits
		peek_at(12'd3);
		seek_for(32'hFFFF_FFFF);                          // no match, runs dry
		put_byte(8'h11);
		put_byte(8'h22);
		put_byte(8'h33);
		seek_for(32'h0033_2211);                          // under one word held
		take_bytes(1);
		issue(CMD_UNUSED_LO, 8'($urandom), $urandom, 12'($urandom));
		issue(CMD_UNUSED_HI, 8'($urandom), $urandom, 12'($urandom));
		issue(CMD_CLEAR, 8'($urandom), $urandom, 12'($urandom));

		// smallest ring: fill it past full so writes get dropped and both
		// positions wrap, then continue with mixed traffic on the full ring
		set_capacity(13'd0);
		filled = 0;
		idx    = 0;
		while (filled < FILL_BYTES) begin
			put_frame(idx, 1 + idx % 6);
			filled += 4 + 4 * (1 + idx % 6);
			if ($urandom_range(0, 4) == 0) peek_at(12'($urandom_range(0, 4095)));
			idx = (idx + 1) % 8;
		end
		phase_end = FILL_ITEMS;
		while (sent < phase_end) mixed_action();

		// sweep of further capacity settings, one random in-range value last
		foreach (SWEEP_CAPS[i]) begin
			set_capacity(SWEEP_CAPS[i]);
			phase_end = sent + SWEEP_ITEMS;
			while (sent < phase_end) mixed_action();
		end
		set_capacity(CAP_W'($urandom_range(1029, 4092)));
		phase_end = sent + SWEEP_ITEMS;
		while (sent < phase_end) mixed_action();

		// drain and let the block settle before the verdict
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && outstanding == 0) begin
			$display("byte_ring_buffer_with_marker_seek_top verification clean");
		end else begin
			$display("byte_ring_buffer_with_marker_seek_top verification failed");
		end
		$finish;
	end

endmodule
